>>> design/tmcs_pkg.sv
// Shared types and constants for the texture mip chain size unit.
`default_nettype none

package tmcs_pkg;

   // Dimension width after wrap; the lane count and the sum widths below follow from it.
   localparam int DIM_BITS = 16;

   localparam int EXP_W   = 4;
   localparam int DIR_W   = 16;
   localparam int FMT_W   = 4;
   localparam int ALIGN_W = 5;
   localparam int SIZE_W  = 32;

   // One lane per mip level, base level included; lanes padded to whole groups.
   localparam int NUM_LEVELS      = DIM_BITS + 1;
   localparam int LANES_PER_GROUP = 4;
   localparam int NUM_GROUPS      = (NUM_LEVELS + LANES_PER_GROUP - 1) / LANES_PER_GROUP;
   localparam int NUM_LANES       = NUM_GROUPS * LANES_PER_GROUP;

   localparam int LVL_W = 2 * DIM_BITS;            // one level's pixel count
   localparam int GRP_W = LVL_W + 2;               // sum of one lane group
   localparam int PIX_W = 2 * DIM_BITS + 1;        // whole chain, below 4/3 of base
   localparam int ALN_W = ((PIX_W > 31) ? PIX_W : 31) + 1;  // after 2^31 alignment
   localparam int CUB_W = ALN_W + 3;               // after six faces
   localparam int BYT_W = CUB_W + 2;               // after 32 bpp / 8

   localparam int MIN_LEVEL_PIXELS = 16;           // compressed block floor

   localparam int PIPE_DEPTH = 6;                  // accept edge to result strobe

   // Configuration port.
   localparam int CFG_ADDR_W = 3;
   localparam int CFG_DATA_W = 32;
   localparam logic REG_CUBE_ALIGN = 1'b0;         // register index, paddr[2]

   // Format codes.
   localparam logic [FMT_W-1:0] FMT_DXT1            = 4'd0;
   localparam logic [FMT_W-1:0] FMT_LAST_COMPRESSED = 4'd2;
   localparam logic [FMT_W-1:0] FMT_LAST_8BIT       = 4'd5;
   localparam logic [FMT_W-1:0] FMT_FIRST_32BIT     = 4'd6;
   localparam logic [FMT_W-1:0] FMT_LAST_32BIT      = 4'd7;
   localparam logic [FMT_W-1:0] FMT_FIRST_16BIT     = 4'd8;
   localparam logic [FMT_W-1:0] FMT_LAST_16BIT      = 4'd10;
   localparam logic [FMT_W-1:0] FMT_FIRST_NONE      = 4'd11;

   typedef enum logic [2:0] {
      BPP_NONE,
      BPP_4,
      BPP_8,
      BPP_16,
      BPP_32
   } bpp_type;

   typedef struct packed {
      logic [EXP_W-1:0] width_exp;
      logic [EXP_W-1:0] height_exp;
      logic [DIR_W-1:0] width_minus_one;
      logic [DIR_W-1:0] height_minus_one;
      logic [FMT_W-1:0] format_code;
      logic             full_mips;
      logic             cubemap;
   } req_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size_bytes;
      logic              too_large;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [DIM_BITS-1:0] width;
      logic [DIM_BITS-1:0] height;
      logic                compressed;
      logic                full_mips;
      logic                cubemap;
      bpp_type             bpp;
   } dims_type;

   typedef struct packed {
      logic             valid;
      logic [PIX_W-1:0] pixels;
      logic             cubemap;
      bpp_type          bpp;
   } pix_type;

   typedef struct packed {
      logic    valid;
      logic    cubemap;
      bpp_type bpp;
   } ctl_type;

endpackage

`default_nettype wire

>>> design/tmcs_csr.sv
// Configuration register file: cubemap alignment register on an APB-style port.
`default_nettype none

module tmcs_csr
   import tmcs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CFG_ADDR_W-1:0] paddr,
   input  wire logic [CFG_DATA_W-1:0] pwdata,
   output      logic [CFG_DATA_W-1:0] prdata,
   output      logic                  pready,
   output      logic [ALIGN_W-1:0]    cube_align_log2
);

   logic [ALIGN_W-1:0] cube_align_ff;
   logic [ALIGN_W-1:0] cube_align_in;
   logic               reg_hit;

   assign reg_hit = (paddr[2] == REG_CUBE_ALIGN);

   always_comb begin
      cube_align_in = cube_align_ff;
      if (psel && penable && pwrite && reg_hit) begin
         cube_align_in = pwdata[ALIGN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cube_align_ff <= '0;
      end else begin
         cube_align_ff <= cube_align_in;
      end
   end

   assign prdata          = reg_hit ? CFG_DATA_W'(cube_align_ff) : '0;
   assign pready          = 1'b1;
   assign cube_align_log2 = cube_align_ff;

endmodule

`default_nettype wire

>>> design/tmcs_decode.sv
// Stage 1: resolve base dimensions, compression and bits per pixel.
`default_nettype none

module tmcs_decode
   import tmcs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire req_type  req,
   output      dims_type dims
);

   dims_type dims_ff;
   dims_type dims_in;
   logic     direct;

   always_comb begin
      direct          = (req.width_minus_one != '0) || (req.height_minus_one != '0);
      dims_in.valid   = in_valid;
      if (direct) begin
         dims_in.width  = req.width_minus_one[DIM_BITS-1:0] + DIM_BITS'(1);
         dims_in.height = req.height_minus_one[DIM_BITS-1:0] + DIM_BITS'(1);
      end else begin
         // exponents of DIM_BITS or more shift the one out
         dims_in.width  = DIM_BITS'(1) << req.width_exp;
         dims_in.height = DIM_BITS'(1) << req.height_exp;
      end
      dims_in.compressed = (req.format_code <= FMT_LAST_COMPRESSED);
      dims_in.full_mips  = req.full_mips;
      dims_in.cubemap    = req.cubemap;
      if (req.format_code == FMT_DXT1) begin
         dims_in.bpp = BPP_4;
      end else if (req.format_code <= FMT_LAST_8BIT) begin
         dims_in.bpp = BPP_8;
      end else if (req.format_code inside {[FMT_FIRST_32BIT:FMT_LAST_32BIT]}) begin
         dims_in.bpp = BPP_32;
      end else if (req.format_code inside {[FMT_FIRST_16BIT:FMT_LAST_16BIT]}) begin
         dims_in.bpp = BPP_16;
      end else begin
         dims_in.bpp = BPP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.valid <= 1'b0;
      end else begin
         dims_ff <= dims_in;
      end
   end

   assign dims = dims_ff;

endmodule

`default_nettype wire

>>> design/tmcs_level_sum.sv
// Stages 2-4: per-level pixel counts in parallel lanes, then a registered adder tree.
`default_nettype none

module tmcs_level_sum
   import tmcs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire dims_type dims,
   output      pix_type  pix
);

   // stage 2: one lane per level
   logic [LVL_W-1:0] lvl_ff [NUM_LANES];
   logic [LVL_W-1:0] lvl_in [NUM_LANES];
   ctl_type          ctl2_ff;
   // stage 3: lane group sums
   logic [GRP_W-1:0] grp_ff [NUM_GROUPS];
   logic [GRP_W-1:0] grp_in [NUM_GROUPS];
   ctl_type          ctl3_ff;
   // stage 4: chain total
   pix_type          pix_ff;
   pix_type          pix_in;

   always_comb begin
      logic [DIM_BITS-1:0] lane_w;
      logic [DIM_BITS-1:0] lane_h;
      logic [LVL_W-1:0]    prod;
      for (int k = 0; k < NUM_LANES; k++) begin
         lane_w = dims.width >> k;
         lane_h = dims.height >> k;
         prod   = LVL_W'(lane_w) * LVL_W'(lane_h);
         if (k == 0) begin
            lvl_in[k] = prod;                 // base level is never clamped
         end else if (!dims.full_mips) begin
            lvl_in[k] = '0;
         end else if (dims.compressed) begin
            // an empty level ends the chain; all later ones are empty too
            if (prod == '0) begin
               lvl_in[k] = '0;
            end else if (prod < LVL_W'(MIN_LEVEL_PIXELS)) begin
               lvl_in[k] = LVL_W'(MIN_LEVEL_PIXELS);
            end else begin
               lvl_in[k] = prod;
            end
         end else begin
            lvl_in[k] = prod;
         end
      end
   end

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < LANES_PER_GROUP; j++) begin
            grp_in[g] = grp_in[g] + GRP_W'(lvl_ff[g * LANES_PER_GROUP + j]);
         end
      end
   end

   always_comb begin
      pix_in.valid   = ctl3_ff.valid;
      pix_in.cubemap = ctl3_ff.cubemap;
      pix_in.bpp     = ctl3_ff.bpp;
      pix_in.pixels  = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         pix_in.pixels = pix_in.pixels + PIX_W'(grp_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
         pix_ff.valid  <= 1'b0;
      end else begin
         ctl2_ff.valid <= dims.valid;
         ctl3_ff.valid <= ctl2_ff.valid;
         pix_ff.valid  <= pix_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff          <= lvl_in;
      grp_ff          <= grp_in;
      ctl2_ff.cubemap <= dims.cubemap;
      ctl2_ff.bpp     <= dims.bpp;
      ctl3_ff.cubemap <= ctl2_ff.cubemap;
      ctl3_ff.bpp     <= ctl2_ff.bpp;
      pix_ff.pixels   <= pix_in.pixels;
      pix_ff.cubemap  <= pix_in.cubemap;
      pix_ff.bpp      <= pix_in.bpp;
   end

   assign pix = pix_ff;

endmodule

`default_nettype wire

>>> design/tmcs_scale.sv
// Stages 5-6: cubemap alignment and six faces, then bytes per format with saturation.
`default_nettype none

module tmcs_scale
   import tmcs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pix_type            pix,
   input  wire logic [ALIGN_W-1:0] cube_align_log2,
   output      logic               rsp_strobe,
   output      rsp_type            rsp_item
);

   logic [CUB_W-1:0] count_ff;
   logic [CUB_W-1:0] count_in;
   ctl_type          ctl5_ff;
   logic             strobe_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   always_comb begin
      logic [ALN_W-1:0] mask;
      logic [ALN_W-1:0] aligned;
      mask    = (ALN_W'(1) << cube_align_log2) - ALN_W'(1);
      aligned = (ALN_W'(pix.pixels) + mask) & ~mask;
      if (pix.cubemap) begin
         count_in = (CUB_W'(aligned) << 2) + (CUB_W'(aligned) << 1);
      end else begin
         count_in = CUB_W'(pix.pixels);
      end
   end

   always_comb begin
      logic [BYT_W-1:0] bytes;
      case (ctl5_ff.bpp)
         BPP_4:   bytes = BYT_W'(count_ff >> 1);
         BPP_8:   bytes = BYT_W'(count_ff);
         BPP_16:  bytes = BYT_W'(count_ff) << 1;
         BPP_32:  bytes = BYT_W'(count_ff) << 2;
         default: bytes = '0;
      endcase
      rsp_in.too_large  = |bytes[BYT_W-1:SIZE_W];
      rsp_in.size_bytes = rsp_in.too_large ? '1 : bytes[SIZE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff.valid <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         ctl5_ff.valid <= pix.valid;
         strobe_ff     <= ctl5_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      count_ff        <= count_in;
      ctl5_ff.cubemap <= pix.cubemap;
      ctl5_ff.bpp     <= pix.bpp;
      rsp_ff          <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

>>> design/texture_mip_chain_size_unit.sv
// Top level of the texture mip chain size unit: ports, pipeline stages, checks.
`default_nettype none

// Texture mip chain size unit. Each beat on the request side carries one
// texture descriptor. Exactly one response beat carries its size in bytes,
// driven from the registers of the last stage.
// The strobe lasts one cycle, and the receiver must
// take it as it comes. busy is never raised: the block is a six-stage
// pipeline that takes a new descriptor every cycle, one beat per clock
// sustained. The pipeline is: dimension and format decode; one multiplier
// lane per mip level (padded to NUM_LANES); lane-group sums; chain total;
// cubemap alignment and six faces; bits-per-pixel scaling with saturation.
// Sizes above 32 bits return all ones with too_large set.
// The alignment register (byte address 0) is read in the fifth stage, so
// write it only while no beat is in flight. No clearing pass after reset.
module texture_mip_chain_size_unit
   import tmcs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request side
   input  wire logic                  start,
   output      logic                  busy,
   input  wire req_type               req_item,
   // response side
   output      logic                  rsp_strobe,
   output      rsp_type               rsp_item,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CFG_ADDR_W-1:0] paddr,
   input  wire logic [CFG_DATA_W-1:0] pwdata,
   output      logic [CFG_DATA_W-1:0] prdata,
   output      logic                  pready
);

   logic               req_accept;
   logic [ALIGN_W-1:0] cube_align_log2;
   dims_type           dims;
   pix_type            pix;

   // every stage advances every cycle, so nothing ever holds off a request
   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   tmcs_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .cube_align_log2 (cube_align_log2)
   );

   // stage 1
   tmcs_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_accept),
      .req      (req_item),
      .dims     (dims)
   );

   // stages 2 to 4
   tmcs_level_sum u_level_sum (
      .clock (clock),
      .reset (reset),
      .dims  (dims),
      .pix   (pix)
   );

   // stages 5 and 6
   tmcs_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .pix             (pix),
      .cube_align_log2 (cube_align_log2),
      .rsp_strobe      (rsp_strobe),
      .rsp_item        (rsp_item)
   );

   // a response beat only ever follows an accepted request by the pipeline depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_accept, PIPE_DEPTH))
      else $error("response beat without a matching request");

   // saturation: the flag and the all-ones size go together
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.too_large |-> (rsp_item.size_bytes == '1))
      else $error("too_large set without saturated size");

   // formats without bits per pixel always give an empty texture
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && ($past(req_item.format_code, PIPE_DEPTH) >= FMT_FIRST_NONE)
      |-> (rsp_item.size_bytes == '0) && !rsp_item.too_large)
      else $error("unknown format gave a nonzero size");

endmodule

`default_nettype wire

>>> verif/tb_texture_mip_chain_size_unit.sv
// Testbench for the texture mip chain size unit: directed and random descriptors, checked sizes.
`timescale 1ns / 1ps

module tb_texture_mip_chain_size_unit;
   import tmcs_pkg::*;

   localparam int RESET_CYCLES    = 6;
   localparam int RANDOM_PHASES   = 6;
   localparam int DESC_PER_PHASE  = 300;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int REPORT_LIMIT    = 10;
   localparam logic [CFG_ADDR_W-1:0] CUBE_ALIGN_ADDR = {REG_CUBE_ALIGN, 2'b00};

   // One accepted descriptor together with the size it must produce.
   typedef struct {
      req_type desc;
      rsp_type size;
   } sized_desc_type;

   logic                  clock;
   logic                  reset    = 1'b1;
   logic                  start    = 1'b0;
   logic                  busy;
   req_type               req_item = '0;
   logic                  rsp_strobe;
   rsp_type               rsp_item;
   logic                  psel     = 1'b0;
   logic                  penable  = 1'b0;
   logic                  pwrite   = 1'b0;
   logic [CFG_ADDR_W-1:0] paddr    = '0;
   logic [CFG_DATA_W-1:0] pwdata   = '0;
   logic [CFG_DATA_W-1:0] prdata;
   logic                  pready;

   // Descriptors waiting to be driven, and sizes waiting to come back.
   req_type        pending_desc[$];
   sized_desc_type expected_sizes[$];

   // Our own copy of the alignment register.
   logic [ALIGN_W-1:0] cube_align_cfg = '0;

   logic        req_taken = 1'b0;
   int unsigned desc_queued     = 0;
   int unsigned desc_accepted   = 0;
   int unsigned sizes_checked   = 0;
   int unsigned saturated_sizes = 0;
   int unsigned cube_descs      = 0;
   int unsigned align_writes    = 0;
   int unsigned drain_pauses    = 0;
   int unsigned mismatches      = 0;
   int unsigned quiet_cycles    = 0;

   // Sender pacing: idle rate per phase.
   int unsigned sender_idle_pct = 0;
   bit          drain_hold      = 1'b0;

   texture_mip_chain_size_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Byte size of one texture descriptor under the given cubemap alignment.
   // All arithmetic is done in 64 bits, which covers the worst case exactly.
   function automatic rsp_type texture_size_bytes(input req_type d,
                                                  input logic [ALIGN_W-1:0] align);
      logic [63:0] dim_mask;
      logic [63:0] w;
      logic [63:0] h;
      logic [63:0] lvl;
      logic [63:0] pixels;
      logic [63:0] align_mask;
      logic [63:0] bits;
      logic [63:0] bytes;
      logic        compressed;
      logic        chain_done;
      rsp_type     res;
      dim_mask   = (64'd1 << DIM_BITS) - 64'd1;
      compressed = (d.format_code <= FMT_LAST_COMPRESSED);
      chain_done = 1'b0;
      // Both direct sizes zero: fall back to the power-of-two exponents.
      if (d.width_minus_one == '0 && d.height_minus_one == '0) begin
         w = (64'd1 << d.width_exp) & dim_mask;
         h = (64'd1 << d.height_exp) & dim_mask;
      end else begin
         w = (64'(d.width_minus_one) + 64'd1) & dim_mask;
         h = (64'(d.height_minus_one) + 64'd1) & dim_mask;
      end
      pixels = w * h;
      if (d.full_mips) begin
         // Halve both sides until the width runs out. Compressed chains stop
         // at the first empty level and floor every added level at one block.
         while (w != 64'd0 && !chain_done) begin
            w   = w >> 1;
            h   = h >> 1;
            lvl = w * h;
            if (compressed && lvl == 64'd0)
               chain_done = 1'b1;
            else begin
               if (compressed && lvl < 64'(MIN_LEVEL_PIXELS))
                  lvl = 64'(MIN_LEVEL_PIXELS);
               pixels = pixels + lvl;
            end
         end
      end
      if (d.cubemap) begin
         align_mask = (64'd1 << align) - 64'd1;
         pixels     = ((pixels + align_mask) & ~align_mask) * 64'd6;
      end
      if (d.format_code == FMT_DXT1)
         bits = 64'd4;
      else if (d.format_code <= FMT_LAST_8BIT)
         bits = 64'd8;
      else if (d.format_code <= FMT_LAST_32BIT)
         bits = 64'd32;
      else if (d.format_code <= FMT_LAST_16BIT)
         bits = 64'd16;
      else
         bits = 64'd0;
      bytes = (pixels * bits) / 64'd8;
      if (bytes > 64'hFFFF_FFFF) begin
         res.size_bytes = '1;
         res.too_large  = 1'b1;
      end else begin
         res.size_bytes = bytes[SIZE_W-1:0];
         res.too_large  = 1'b0;
      end
      return res;
   endfunction

   function automatic req_type make_desc(input logic [EXP_W-1:0] wexp, hexp,
                                         input logic [DIR_W-1:0] wmo, hmo,
                                         input logic [FMT_W-1:0] fmt,
                                         input logic full, cube);
      req_type d;
      d.width_exp        = wexp;
      d.height_exp       = hexp;
      d.width_minus_one  = wmo;
      d.height_minus_one = hmo;
      d.format_code      = fmt;
      d.full_mips        = full;
      d.cubemap          = cube;
      return d;
   endfunction

   // Random descriptor: sizes spread over every magnitude, with extra weight
   // on exponent mode, one-sided direct sizes, wrap edges and block formats.
   function automatic req_type random_desc();
      req_type     d;
      int unsigned pick;
      d.width_exp   = EXP_W'($urandom_range(15, 0));
      d.height_exp  = EXP_W'($urandom_range(15, 0));
      d.format_code = FMT_W'(($urandom_range(99, 0) < 25) ?
                      $urandom_range(FMT_LAST_COMPRESSED, FMT_DXT1) : $urandom_range(15, 0));
      d.full_mips   = ($urandom_range(99, 0) < 60);
      d.cubemap     = ($urandom_range(99, 0) < 35);
      d.width_minus_one  = DIR_W'($urandom_range(16'hFFFF, 0) >> $urandom_range(16, 0));
      d.height_minus_one = DIR_W'($urandom_range(16'hFFFF, 0) >> $urandom_range(16, 0));
      pick = $urandom_range(99, 0);
      if (pick < 20) begin
         d.width_minus_one  = '0;
         d.height_minus_one = '0;
      end else if (pick < 25)
         d.width_minus_one = '0;
      else if (pick < 30)
         d.height_minus_one = '0;
      else if (pick < 36) begin
         d.width_minus_one  = $urandom_range(1, 0) ? '1 : d.width_minus_one;
         d.height_minus_one = $urandom_range(1, 0) ? '1 : 16'hFFFE;
      end
      return d;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got, input req_type d);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("ERROR %0t: %s expected %0d (0x%0h) got %0d (0x%0h), descriptor %h",
                  $time, what, want, want, got, got, d);
   endtask

   task automatic queue_desc(input req_type d);
      pending_desc.push_back(d);
      desc_queued++;
   endtask

   // Hold until every queued descriptor is taken and every size has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      while (desc_accepted != desc_queued || expected_sizes.size() != 0)
         @(negedge clock);
   endtask

   // Write the alignment register, then read it back. Upper data bits carry
   // noise, which the register must drop.
   task automatic write_cube_align(input logic [ALIGN_W-1:0] value);
      logic [CFG_DATA_W-1:0] readback;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CUBE_ALIGN_ADDR;
      pwdata  <= {(CFG_DATA_W - ALIGN_W)'($urandom_range(32'h07FF_FFFF, 0)), value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      cube_align_cfg = value;
      align_writes++;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback[ALIGN_W-1:0] !== value)
         note_mismatch("cube_align_log2 readback", 64'(value),
                       64'(readback[ALIGN_W-1:0]), '0);
   endtask

   // Driver: change inputs on the falling edge. Hold a beat until it is taken,
   // then advance to the next pending descriptor unless the sender idles or
   // a drain pause is in effect.
   always @(negedge clock) begin : driver
      bit sender_idle;
      sender_idle = 1'b0;
      if (reset)
         start <= 1'b0;
      else if (!(start && !req_taken)) begin
         if (drain_hold && expected_sizes.size() == 0)
            drain_hold = 1'b0;
         if (!drain_hold && pending_desc.size() != 0 && $urandom_range(199, 0) == 0) begin
            drain_hold = 1'b1;
            drain_pauses++;
         end
         sender_idle = ($urandom_range(99, 0) < sender_idle_pct);
         if (pending_desc.size() == 0 || drain_hold || sender_idle)
            start <= 1'b0;
         else begin
            start    <= 1'b1;
            req_item <= pending_desc.pop_front();
         end
      end
   end

   // Monitor: sample on the rising edge. Check a result beat against the
   // oldest expectation first, then predict the size of a newly taken
   // descriptor. Also guard against a stalled run.
   always @(posedge clock) begin : monitor
      sized_desc_type head;
      sized_desc_type fresh;
      bit             beat_moved;
      beat_moved = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            beat_moved = 1'b1;
            if (expected_sizes.size() == 0)
               note_mismatch("result with nothing outstanding, size_bytes", 64'd0,
                             64'(rsp_item.size_bytes), '0);
            else begin
               head = expected_sizes.pop_front();
               if (rsp_item.size_bytes !== head.size.size_bytes)
                  note_mismatch("size_bytes", 64'(head.size.size_bytes),
                                64'(rsp_item.size_bytes), head.desc);
               if (rsp_item.too_large !== head.size.too_large)
                  note_mismatch("too_large", 64'(head.size.too_large),
                                64'(rsp_item.too_large), head.desc);
               sizes_checked++;
               if (head.size.too_large)
                  saturated_sizes++;
            end
         end
         if (start && !busy) begin
            beat_moved = 1'b1;
            fresh.desc = req_item;
            fresh.size = texture_size_bytes(req_item, cube_align_cfg);
            expected_sizes.push_back(fresh);
            desc_accepted++;
            if (req_item.cubemap)
               cube_descs++;
         end
      end
      req_taken <= !reset && start && !busy;
      quiet_cycles = beat_moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      int k;
      int phase;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed descriptors at alignment 1.
      write_cube_align('0);
      // smallest texture, and largest exponent texture as a full cubemap
      queue_desc(make_desc(4'd0, 4'd0, 16'd0, 16'd0, FMT_DXT1, 1'b0, 1'b0));
      queue_desc(make_desc(4'd15, 4'd15, 16'd0, 16'd0, FMT_FIRST_32BIT, 1'b1, 1'b1));
      // direct sizes of all ones wrap both sides to zero
      queue_desc(make_desc(4'd15, 4'd15, 16'hFFFF, 16'hFFFF, FMT_LAST_32BIT, 1'b1, 1'b0));
      // zero width with unit height, and one-pixel width with a direct height
      queue_desc(make_desc(4'd0, 4'd0, 16'hFFFF, 16'h0000, FMT_FIRST_16BIT, 1'b1, 1'b1));
      queue_desc(make_desc(4'd0, 4'd0, 16'h0000, 16'h0005, FMT_LAST_16BIT, 1'b1, 1'b0));
      // block formats: level floor, then a chain cut short by an empty level
      queue_desc(make_desc(4'd0, 4'd0, 16'd3, 16'd3, FMT_DXT1, 1'b1, 1'b0));
      queue_desc(make_desc(4'd0, 4'd0, 16'd63, 16'd1, FMT_LAST_COMPRESSED, 1'b1, 1'b0));
      // largest direct size, full chain, six faces, widest pixels: saturates
      queue_desc(make_desc(4'd0, 4'd0, 16'hFFFE, 16'hFFFE, FMT_FIRST_32BIT, 1'b1, 1'b1));
      // every format code once
      for (k = 0; k < 16; k++)
         queue_desc(make_desc(k[3:0], ~k[3:0], 16'(k * 37 + 100), 16'(k * 3 + 50),
                              k[3:0], k[0], k[1]));
      wait_for_drain();

      // Widest alignment: an empty count stays empty, a single pixel saturates.
      write_cube_align('1);
      queue_desc(make_desc(4'd0, 4'd0, 16'hFFFF, 16'h0003, FMT_FIRST_32BIT, 1'b0, 1'b1));
      queue_desc(make_desc(4'd0, 4'd0, 16'd0, 16'd0, FMT_DXT1, 1'b0, 1'b1));
      wait_for_drain();

      // Random phases: sender idles a third of the time, then about two
      // thirds, then never. Alignment changes only between phases.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       write_cube_align(5'd20);
            2:       write_cube_align(5'd1);
            4:       write_cube_align('1);
            default: write_cube_align(ALIGN_W'($urandom_range(31, 0)));
         endcase
         sender_idle_pct = (phase < 2) ? 33 : (phase < 4) ? 64 : 0;
         repeat (DESC_PER_PHASE) queue_desc(random_desc());
         wait_for_drain();
      end

      // Let the pipeline settle, then report.
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      if (expected_sizes.size() != 0)
         note_mismatch("sizes never returned", 64'd0, 64'(expected_sizes.size()), '0);
      $display("Covered %0d descriptors (%0d cubemaps, %0d saturated) over %0d alignment writes;",
               desc_accepted, cube_descs, saturated_sizes, align_writes);
      $display("checked %0d sizes, sender idle at 33/64/0 percent, %0d drain pauses.",
               sizes_checked, drain_pauses);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
